// ----- rtl/trlsq_pkg.sv -----
package trlsq_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned AccWidth    = 48;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned CoefWidth   = 32;
  // A cross difference of two accumulator products needs two accumulator
  // widths plus a sign bit.
  localparam int unsigned CrossWidth  = 2 * AccWidth + 1;
  localparam int unsigned NumWidth    = CrossWidth + FracBits;
  localparam int unsigned QuoBits     = NumWidth;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef logic signed [AccWidth-1:0]    acc_t;
  typedef logic signed [CrossWidth-1:0]  cross_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;

  typedef struct packed {
    logic                          command;
    logic signed [SampleWidth-1:0] input_x;
    logic signed [SampleWidth-1:0] output_y;
    logic signed [SampleWidth-1:0] output_next;
  } in_item_t;

  typedef struct packed {
    coef_t coef_a;
    coef_t coef_b;
    logic  singular;
  } out_item_t;

  // Saturating accumulate of a sample product.
  function automatic acc_t sat_add(acc_t s, logic signed [2*SampleWidth-1:0] p);
    logic signed [AccWidth:0] t;
    t = {s[AccWidth-1], s} + (AccWidth+1)'(p);
    if (t[AccWidth] != t[AccWidth-1]) begin
      sat_add = t[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    end else begin
      sat_add = t[AccWidth-1:0];
    end
  endfunction

endpackage

// ----- rtl/trlsq_if.sv -----
interface trlsq_in_if;
  logic                valid;
  logic                ready;
  trlsq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trlsq_out_if;
  logic                 valid;
  logic                 ready;
  trlsq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/trlsq_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, with the quotient
// saturated to the signed coefficient range and the sign applied at the end.
module trlsq_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [trlsq_pkg::CrossWidth-1:0] num_i,
  input  logic [trlsq_pkg::CrossWidth-1:0] den_i,
  input  logic                             neg_i,
  output logic                             done_o,
  output trlsq_pkg::coef_t                 quo_o
);
  localparam int unsigned NW = trlsq_pkg::NumWidth;
  localparam int unsigned CW = trlsq_pkg::CoefWidth;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]              num_q, num_d;
  logic [trlsq_pkg::CrossWidth:0] rem_q, rem_d;
  logic [CW:0]                quo_q, quo_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d, neg_q, neg_d;
  logic [trlsq_pkg::CrossWidth:0] shifted, diff;

  always_comb begin
    shifted = {rem_q[trlsq_pkg::CrossWidth-1:0], num_q[NW-1]};
    diff    = shifted - {1'b0, den_i};
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q;
    if (start_i) begin
      num_d  = {num_i, {trlsq_pkg::FracBits{1'b0}}};
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NW);
      busy_d = 1'b1;
      neg_d  = neg_i;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (!diff[trlsq_pkg::CrossWidth]) begin
        rem_d = diff;
      end else begin
        rem_d = shifted;
      end
      // The quotient holds a sticky top bit once it passes the coefficient range.
      quo_d = {quo_q[CW] | quo_q[CW-1], quo_q[CW-2:0], ~diff[trlsq_pkg::CrossWidth]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));

  logic [CW:0] qf;
  logic        big;
  always_comb begin
    qf  = {quo_q[CW] | quo_q[CW-1], quo_q[CW-2:0], ~diff[trlsq_pkg::CrossWidth]};
    big = qf[CW];
    if (neg_q) begin
      if (big || qf[CW-1]) quo_o = {1'b1, {(CW-1){1'b0}}};
      else quo_o = -$signed(qf[CW-1:0]);
    end else begin
      if (big || qf[CW-1]) quo_o = {1'b0, {(CW-1){1'b1}}};
      else quo_o = $signed(qf[CW-1:0]);
    end
  end
endmodule

// ----- rtl/two_regressor_least_squares_core.sv -----
// Two-regressor least-squares fit without intercept (next = a*y + b*x). Each
// item either adds a sample triple to five saturating 48-bit product sums or
// clears them, and always yields one result holding a and b in signed Q15.16,
// saturated, with a singular flag when the determinant is zero. The block
// handles one item at a time. A single 24x24 multiplier forms the six 48x48
// products of the normal equations in turn, from four partial products each.
// One restoring divider produces each quotient a bit per cycle. After an
// item is accepted, the sums are updated, the products are formed, each
// quotient is produced in turn and the output register is loaded. A clear
// item or a singular fit skips the divisions. The result waits in an output
// register, and the next item is accepted only after the result is taken
// and the sequencer has gone back to idle.
module two_regressor_least_squares_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  trlsq_in_if.sink      in_if,
  trlsq_out_if.source   out_if
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ACC  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_DIVA = 4'd3;
  localparam logic [3:0] ST_DIVB = 4'd4;
  localparam logic [3:0] ST_OUT  = 4'd5;
  localparam logic [3:0] ST_WAIT = 4'd6;
  localparam int unsigned XW = trlsq_pkg::CrossWidth;
  localparam int unsigned AW = trlsq_pkg::AccWidth;
  localparam int unsigned HW = AW / 2;
  localparam int unsigned MW = 2 * AW;

  logic [3:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [2:0] part_q, part_d;
  trlsq_pkg::acc_t s_yy_q, s_xy_q, s_xx_q, s_yn_q, s_xn_q;
  trlsq_pkg::in_item_t item_q;
  trlsq_pkg::cross_t prod_q, den_q, na_q, nb_q;
  trlsq_pkg::out_item_t res_q;
  logic out_valid_q;
  trlsq_pkg::acc_t ma, mb;
  logic msign;
  logic [AW-1:0] ua, ub;
  logic [HW-1:0] pa, pb;
  logic [AW-1:0] pp;
  logic [MW-1:0] pp_sh, macc_q;
  trlsq_pkg::cross_t mag_s, prod, diff_s;
  logic div_start, div_done, div_neg;
  logic [XW-1:0] div_num, div_den;
  trlsq_pkg::coef_t div_quo;

  // Products in turn: yy*xx, xy*xy, xx*yn, xy*xn, yy*xn, xy*yn.
  always_comb begin
    unique case (step_q)
      3'd0: begin ma = s_yy_q; mb = s_xx_q; end
      3'd1: begin ma = s_xy_q; mb = s_xy_q; end
      3'd2: begin ma = s_xx_q; mb = s_yn_q; end
      3'd3: begin ma = s_xy_q; mb = s_xn_q; end
      3'd4: begin ma = s_yy_q; mb = s_xn_q; end
      3'd5: begin ma = s_xy_q; mb = s_yn_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // The magnitudes are multiplied half by half from four partial products; a
  // final step applies the sign.
  always_comb begin
    msign = ma[AW-1] ^ mb[AW-1];
    ua = $unsigned(ma[AW-1] ? -ma : ma);
    ub = $unsigned(mb[AW-1] ? -mb : mb);
    pa = part_q[1] ? ua[AW-1:HW] : ua[HW-1:0];
    pb = part_q[0] ? ub[AW-1:HW] : ub[HW-1:0];
    pp = {{HW{1'b0}}, pa} * {{HW{1'b0}}, pb};
    case (part_q[1:0])
      2'd0:    pp_sh = {{AW{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {AW{1'b0}}};
      default: pp_sh = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  assign mag_s  = $signed({1'b0, macc_q});
  assign prod   = msign ? -mag_s : mag_s;
  assign diff_s = msign ? prod_q + mag_s : prod_q - mag_s;

  function automatic logic [XW-1:0] mag(trlsq_pkg::cross_t v);
    mag = v[XW-1] ? XW'(-v) : XW'(v);
  endfunction

  assign div_den   = mag(den_q);
  assign div_start = (state_q == ST_MUL && step_q == 3'd6 && den_q != '0) ||
                     (state_q == ST_DIVA && div_done);
  assign div_num   = (state_q == ST_DIVA) ? mag(nb_q) : mag(na_q);
  assign div_neg   = ((state_q == ST_DIVA) ? nb_q[XW-1] : na_q[XW-1]) ^ den_q[XW-1];

  trlsq_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .neg_i(div_neg), .done_o(div_done), .quo_o(div_quo)
  );

  assign in_if.ready  = (state_q == ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = res_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    part_d  = part_q;
    unique case (state_q)
      ST_IDLE: if (in_if.valid) state_d = ST_ACC;
      ST_ACC: begin
        state_d = ST_MUL;
        step_d  = 3'd0;
        part_d  = 3'd0;
      end
      ST_MUL: begin
        if (step_q == 3'd6) begin
          state_d = (den_q == '0) ? ST_OUT : ST_DIVA;
        end else if (part_q == 3'd4) begin
          part_d = 3'd0;
          step_d = step_q + 3'd1;
        end else begin
          part_d = part_q + 3'd1;
        end
      end
      ST_DIVA: if (div_done) state_d = ST_DIVB;
      ST_DIVB: if (div_done) state_d = ST_OUT;
      ST_OUT:  state_d = ST_WAIT;
      ST_WAIT: if (!out_valid_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_OUT && out_valid_q) state_d = ST_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      part_q  <= '0;
      out_valid_q <= 1'b0;
      s_yy_q <= '0; s_xy_q <= '0; s_xx_q <= '0; s_yn_q <= '0; s_xn_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      part_q  <= part_d;
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      if (state_q == ST_OUT && !out_valid_q) out_valid_q <= 1'b1;
      if (state_q == ST_ACC) begin
        if (item_q.command == trlsq_pkg::CMD_CLEAR) begin
          s_yy_q <= '0; s_xy_q <= '0; s_xx_q <= '0; s_yn_q <= '0; s_xn_q <= '0;
        end else begin
          s_yy_q <= trlsq_pkg::sat_add(s_yy_q, item_q.output_y * item_q.output_y);
          s_xy_q <= trlsq_pkg::sat_add(s_xy_q, item_q.input_x * item_q.output_y);
          s_xx_q <= trlsq_pkg::sat_add(s_xx_q, item_q.input_x * item_q.input_x);
          s_yn_q <= trlsq_pkg::sat_add(s_yn_q, item_q.output_y * item_q.output_next);
          s_xn_q <= trlsq_pkg::sat_add(s_xn_q, item_q.input_x * item_q.output_next);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
    if (state_q == ST_MUL && step_q != 3'd6) begin
      if (part_q == 3'd4) begin
        prod_q <= prod;
        unique case (step_q)
          3'd1: den_q <= diff_s;
          3'd3: na_q  <= diff_s;
          3'd5: nb_q  <= diff_s;
          default: ;
        endcase
      end else begin
        macc_q <= ((part_q == 3'd0) ? '0 : macc_q) + pp_sh;
      end
    end
    if (state_q == ST_MUL && step_q == 3'd6 && den_q == '0) begin
      res_q <= '{coef_a: '0, coef_b: '0, singular: 1'b1};
    end
    if (state_q == ST_DIVA && div_done) res_q.coef_a <= div_quo;
    if (state_q == ST_DIVB && div_done) begin
      res_q.coef_b   <= div_quo;
      res_q.singular <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_if.ready)
    else $error("input taken while a result is pending");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.singular) |-> (res_q.coef_a == '0 && res_q.coef_b == '0))
    else $error("singular result with nonzero coefficients");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> (state_q == ST_ACC))
    else $error("sequencer did not start on an accepted item");
endmodule

// ----- sim/tb_top.sv -----
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  trlsq_in_if  in_if ();
  trlsq_out_if out_if ();

  two_regressor_least_squares_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicts the fit after each accepted item and checks the block's results in order.
  class fit_scoreboard;
    trlsq_pkg::acc_t s_yy, s_xy, s_xx, s_yn, s_xn;
    trlsq_pkg::out_item_t pending_fits[$];
    int unsigned mismatches;
    int unsigned fits_checked;
    int unsigned singular_seen;

    function new();
      s_yy = '0; s_xy = '0; s_xx = '0; s_yn = '0; s_xn = '0;
      mismatches = 0;
      fits_checked = 0;
      singular_seen = 0;
    endfunction

    function trlsq_pkg::acc_t clamp_add(trlsq_pkg::acc_t s,
                                        logic signed [2*trlsq_pkg::SampleWidth-1:0] p);
      logic signed [trlsq_pkg::AccWidth+1:0] t;
      t = s + p;
      if (t > $signed({3'b0, {(trlsq_pkg::AccWidth-1){1'b1}}}))
        return {1'b0, {(trlsq_pkg::AccWidth-1){1'b1}}};
      if (t < -$signed({3'b0, {(trlsq_pkg::AccWidth-1){1'b1}}}) - 1)
        return {1'b1, {(trlsq_pkg::AccWidth-1){1'b0}}};
      return t[trlsq_pkg::AccWidth-1:0];
    endfunction

    function trlsq_pkg::coef_t divide_sat(logic signed [trlsq_pkg::NumWidth+1:0] num,
                                          logic signed [trlsq_pkg::NumWidth+1:0] den);
      logic signed [trlsq_pkg::NumWidth+1:0] q;
      q = (num <<< trlsq_pkg::FracBits) / den;
      if (q > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (q < -64'sh8000_0000) return 32'h8000_0000;
      return q[trlsq_pkg::CoefWidth-1:0];
    endfunction

    function void note_item(trlsq_pkg::in_item_t it);
      logic signed [trlsq_pkg::NumWidth+1:0] den, na, nb;
      trlsq_pkg::out_item_t r;
      if (it.command == trlsq_pkg::CMD_CLEAR) begin
        s_yy = '0; s_xy = '0; s_xx = '0; s_yn = '0; s_xn = '0;
      end else begin
        s_yy = clamp_add(s_yy, it.output_y * it.output_y);
        s_xy = clamp_add(s_xy, it.input_x * it.output_y);
        s_xx = clamp_add(s_xx, it.input_x * it.input_x);
        s_yn = clamp_add(s_yn, it.output_y * it.output_next);
        s_xn = clamp_add(s_xn, it.input_x * it.output_next);
      end
      den = $signed(s_yy) * $signed(s_xx) - $signed(s_xy) * $signed(s_xy);
      na  = $signed(s_xx) * $signed(s_yn) - $signed(s_xy) * $signed(s_xn);
      nb  = $signed(s_yy) * $signed(s_xn) - $signed(s_xy) * $signed(s_yn);
      if (den == 0) begin
        r.coef_a = '0; r.coef_b = '0; r.singular = 1'b1;
      end else begin
        r.coef_a = divide_sat(na, den);
        r.coef_b = divide_sat(nb, den);
        r.singular = 1'b0;
      end
      pending_fits.push_back(r);
    endfunction

    function void check_fit(trlsq_pkg::out_item_t got);
      trlsq_pkg::out_item_t want;
      if (pending_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result a=%h b=%h s=%b",
                                       got.coef_a, got.coef_b, got.singular);
        return;
      end
      want = pending_fits.pop_front();
      fits_checked++;
      if (got.singular) singular_seen++;
      if (got.coef_a !== want.coef_a || got.coef_b !== want.coef_b ||
          got.singular !== want.singular) begin
        mismatches++;
        if (mismatches <= 10)
          $display("fit %0d: expected a=%h b=%h s=%b, got a=%h b=%h s=%b", fits_checked,
                   want.coef_a, want.coef_b, want.singular,
                   got.coef_a, got.coef_b, got.singular);
      end
    endfunction
  endclass

  fit_scoreboard fits;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Sample the output at the rising edge, change ready at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) fits.check_fit(out_if.data);
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(trlsq_pkg::in_item_t it);
    do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    fits.note_item(it);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic send_triple(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] n);
    trlsq_pkg::in_item_t it;
    it.command = trlsq_pkg::CMD_ADD;
    it.input_x = x;
    it.output_y = y;
    it.output_next = n;
    send_item(it);
  endtask

  task automatic send_clear();
    trlsq_pkg::in_item_t it;
    it = '0;
    it.command = trlsq_pkg::CMD_CLEAR;
    it.input_x = 16'($urandom);
    it.output_y = 16'($urandom);
    it.output_next = 16'($urandom);
    send_item(it);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(8)) - 4);
      3, 4: return 16'(int'($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int unsigned count);
    logic signed [15:0] a, b, x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 6) begin
        send_clear();
      end else if ($urandom_range(99) < 40) begin
        // Data from a true two-regressor system keeps the fit well-conditioned.
        a = 16'(int'($urandom_range(6)) - 3);
        b = 16'(int'($urandom_range(6)) - 3);
        x = 16'(int'($urandom_range(400)) - 200);
        y = 16'(int'($urandom_range(400)) - 200);
        send_triple(x, y, 16'(a * y + b * x + int'($urandom_range(4)) - 2));
      end else begin
        send_triple(pick_sample(), pick_sample(), pick_sample());
      end
    end
  endtask

  initial begin
    fits = new();
    in_if.valid = 1'b0;
    in_if.data = '0;
    send_idle_pct = 17;
    recv_idle_pct = 83;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: clears, singular fits and extreme samples.
    send_clear();
    send_triple(16'sd0, 16'sd0, 16'sd0);
    send_triple(16'sd256, 16'sd256, 16'sd512);
    send_triple(16'sd256, -16'sd256, 16'sd0);
    send_triple(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_triple(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_triple(-16'sd1, -16'sd1, -16'sd1);
    send_clear();
    send_triple(16'sd1, 16'sd0, 16'sh7FFF);
    send_triple(16'sd0, 16'sd1, 16'sh8000);
    send_triple(16'sd1, 16'sd1, 16'sd0);
    send_clear();
    for (int i = 0; i < 12; i++) send_triple(16'sh8000, 16'sh8000, 16'sh7FFF);
    send_triple(16'sh7FFF, 16'sh8000, 16'sh8000);
    send_clear();

    random_phase(160);
    send_idle_pct = 83;
    recv_idle_pct = 17;
    random_phase(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(160);

    while (fits.pending_fits.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Checked %0d fits, %0d of them singular, over clears, extreme samples",
             fits.fits_checked, fits.singular_seen);
    $display("and three patterns of sender and receiver idling.");
    if (fits.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
